// ===== rtl/acbc_pkg.sv =====
package acbc_pkg;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_MENU   = 3'd1;
  localparam logic [2:0] FUNC_MODE   = 3'd2;
  localparam logic [2:0] FUNC_HOUR   = 3'd3;
  localparam logic [2:0] FUNC_MINUTE = 3'd4;

  localparam logic [1:0] MODE_AM  = 2'd0;
  localparam logic [1:0] MODE_PM  = 2'd1;
  localparam logic [1:0] MODE_24  = 2'd2;
  localparam logic [1:0] MODE_RAW = 2'd3;

  localparam logic [1:0] DRIVE_NONE    = 2'd0;
  localparam logic [1:0] DRIVE_ALL_OFF = 2'd1;
  localparam logic [1:0] DRIVE_TOGGLE  = 2'd2;
  localparam logic [1:0] DRIVE_LED_OFF = 2'd3;

  localparam logic [7:0] HOUR24_MAX  = 8'd23;
  localparam logic [7:0] HOUR12_MAX  = 8'd12;
  localparam logic [7:0] MINUTE_MAX  = 8'd59;
  localparam logic [7:0] WEEKDAY_MAX = 8'd7;
  localparam logic [7:0] MDAY_MAX    = 8'd31;
  localparam logic [7:0] MONTH_MAX   = 8'd12;

  localparam logic [7:0] RING_LIMIT_RESET = 8'd110;

  typedef enum logic [1:0] {
    PAGE_NORMAL   = 2'd0,
    PAGE_CLOCK    = 2'd1,
    PAGE_CALENDAR = 2'd2,
    PAGE_ALARM    = 2'd3
  } page_t;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] rtc_mode;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic [2:0] rtc_weekday;
    logic [4:0] rtc_day_of_month;
    logic [3:0] rtc_month;
  } item_t;

  typedef struct packed {
    logic       time_write;
    logic       cal_write;
    logic [1:0] new_mode;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic [2:0] new_weekday;
    logic [4:0] new_day_of_month;
    logic [3:0] new_month;
    logic [1:0] drive_action;
    logic       backlight_toggle;
    logic [1:0] menu_now;
    logic       alarm_on;
  } result_t;

  function automatic logic [7:0] step_wrap(logic [7:0] v, logic [7:0] max, logic [7:0] low);
    logic [8:0] s;
    s = {1'b0, v} + 9'd1;
    return (s > {1'b0, max}) ? low : s[7:0];
  endfunction

  function automatic logic [4:0] norm_alarm_hour(logic [1:0] mode, logic [4:0] hour);
    logic [4:0] h;
    h = hour;
    if (mode == MODE_AM || mode == MODE_PM) begin
      if (h == 5'd0) begin
        h = 5'd12;
      end else if (h > 5'd12 && h <= 5'd23) begin
        h = h - 5'd12;
      end
    end
    return h;
  endfunction

endpackage

// ===== rtl/alarm_clock_button_controller_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  func, rtc_* time and date fields
// out      output     out_valid / out_stall  write flags, new_* fields, actions, menu_now, alarm_on
// cfg      input      cfg_valid / cfg_ready  cfg_data (ring_limit)
//
// One request per cycle sustained while out_stall stays low.
// The input register feeds one pass of step logic into the result register.
// Synchronous active-high rst returns the menu, alarm and ring state to defaults.
// A stalled result holds the result register; the input register then stalls too.
module alarm_clock_button_controller_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [1:0] rtc_mode,
  input  logic [4:0] rtc_hour,
  input  logic [5:0] rtc_minute,
  input  logic [5:0] rtc_second,
  input  logic [2:0] rtc_weekday,
  input  logic [4:0] rtc_day_of_month,
  input  logic [3:0] rtc_month,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       time_write,
  output logic       cal_write,
  output logic [1:0] new_mode,
  output logic [4:0] new_hour,
  output logic [5:0] new_minute,
  output logic [2:0] new_weekday,
  output logic [4:0] new_day_of_month,
  output logic [3:0] new_month,
  output logic [1:0] drive_action,
  output logic       backlight_toggle,
  output logic [1:0] menu_now,
  output logic       alarm_on,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import acbc_pkg::*;

  item_t   in_item, item;
  result_t step_result, result;
  logic    advance, fire;

  assign cfg_ready = 1'b1;

  assign in_item.func             = func;
  assign in_item.rtc_mode         = rtc_mode;
  assign in_item.rtc_hour         = rtc_hour;
  assign in_item.rtc_minute       = rtc_minute;
  assign in_item.rtc_second       = rtc_second;
  assign in_item.rtc_weekday      = rtc_weekday;
  assign in_item.rtc_day_of_month = rtc_day_of_month;
  assign in_item.rtc_month        = rtc_month;

  acbc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  acbc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (step_result)
  );

  acbc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result_in (step_result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign time_write       = result.time_write;
  assign cal_write        = result.cal_write;
  assign new_mode         = result.new_mode;
  assign new_hour         = result.new_hour;
  assign new_minute       = result.new_minute;
  assign new_weekday      = result.new_weekday;
  assign new_day_of_month = result.new_day_of_month;
  assign new_month        = result.new_month;
  assign drive_action     = result.drive_action;
  assign backlight_toggle = result.backlight_toggle;
  assign menu_now         = result.menu_now;
  assign alarm_on         = result.alarm_on;

endmodule

// ===== rtl/acbc_in_stage.sv =====
module acbc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  acbc_pkg::item_t in_item,
  input  logic            advance,
  output logic            fire,
  output acbc_pkg::item_t item
);
  import acbc_pkg::*;

  logic held;

  assign in_stall = held && !advance;
  assign fire     = held && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/acbc_core.sv =====
module acbc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  acbc_pkg::item_t   item,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  output acbc_pkg::result_t result
);
  import acbc_pkg::*;

  page_t      page, page_next;
  logic [7:0] ring_limit;
  logic [1:0] set_clock_mode, set_clock_mode_next;
  logic [4:0] set_clock_hour, set_clock_hour_next;
  logic [5:0] set_clock_minute, set_clock_minute_next;
  logic [2:0] set_weekday, set_weekday_next;
  logic [4:0] set_day_of_month, set_day_of_month_next;
  logic [3:0] cal_month, cal_month_next;
  logic [1:0] alarm_mode, alarm_mode_next;
  logic [4:0] alarm_hour, alarm_hour_next;
  logic [5:0] alarm_minute, alarm_minute_next;
  logic       alarm_enabled, alarm_enabled_next;
  logic       alarm_ringing, alarm_ringing_next;
  logic [7:0] ring_count, ring_count_next;

  logic       tw, cw, blt, ring_hit;
  logic [1:0] drive, o_mode, am_tmp;
  logic [4:0] o_hour, ah_tmp;
  logic [5:0] o_minute;
  logic [2:0] o_wday;
  logic [4:0] o_mday;
  logic [3:0] o_month;

  always_comb begin
    page_next = page;
    if (item.func == FUNC_MENU) begin
      page_next = page_t'(page + 2'd1);
    end
  end

  always_comb begin
    set_clock_mode_next   = set_clock_mode;
    set_clock_hour_next   = set_clock_hour;
    set_clock_minute_next = set_clock_minute;
    set_weekday_next      = set_weekday;
    set_day_of_month_next = set_day_of_month;
    cal_month_next        = cal_month;
    alarm_mode_next       = alarm_mode;
    alarm_hour_next       = alarm_hour;
    alarm_minute_next     = alarm_minute;
    alarm_enabled_next    = alarm_enabled;
    alarm_ringing_next    = alarm_ringing;
    ring_count_next       = ring_count;
    tw       = 1'b0;
    cw       = 1'b0;
    blt      = 1'b0;
    drive    = DRIVE_NONE;
    ring_hit = 1'b0;
    am_tmp   = alarm_mode;
    ah_tmp   = alarm_hour;
    o_mode   = item.rtc_mode;
    o_hour   = item.rtc_hour;
    o_minute = item.rtc_minute;
    o_wday   = item.rtc_weekday;
    o_mday   = item.rtc_day_of_month;
    o_month  = item.rtc_month;
    case (item.func)
      FUNC_TICK: begin
        if (page == PAGE_NORMAL) begin
          ring_hit = alarm_ringing ||
                     (alarm_mode == item.rtc_mode && alarm_hour == item.rtc_hour &&
                      alarm_minute == item.rtc_minute && item.rtc_second == 6'd0);
          alarm_ringing_next = ring_hit;
          if (!ring_hit || !alarm_enabled) begin
            ring_count_next = 8'd0;
            drive = DRIVE_ALL_OFF;
          end else begin
            drive = DRIVE_TOGGLE;
            if (ring_count >= ring_limit) begin
              alarm_ringing_next = 1'b0;
              ring_count_next = 8'd0;
            end else begin
              ring_count_next = ring_count + 8'd1;
            end
          end
        end
      end
      FUNC_MENU: begin
        if (page_next == PAGE_NORMAL) begin
          set_clock_hour_next   = 5'd0;
          set_clock_minute_next = 6'd0;
          set_weekday_next      = 3'd1;
          set_day_of_month_next = 5'd1;
          cal_month_next        = 4'd1;
        end else if (page_next == PAGE_ALARM) begin
          alarm_hour_next = norm_alarm_hour(alarm_mode, alarm_hour);
        end
      end
      FUNC_MODE: begin
        case (page)
          PAGE_NORMAL: begin
            if (item.rtc_mode == MODE_24) begin
              if (item.rtc_hour == 5'd0) begin
                o_mode = MODE_AM;
                o_hour = 5'd12;
              end else if (item.rtc_hour < 5'd12) begin
                o_mode = MODE_AM;
              end else if (item.rtc_hour == 5'd12) begin
                o_mode = MODE_PM;
              end else begin
                o_mode = MODE_PM;
                o_hour = item.rtc_hour - 5'd12;
              end
            end else if (item.rtc_mode == MODE_AM) begin
              o_mode = MODE_24;
              if (item.rtc_hour == 5'd12) begin
                o_hour = 5'd0;
              end
            end else if (item.rtc_mode == MODE_PM) begin
              o_mode = MODE_24;
              if (item.rtc_hour != 5'd12) begin
                o_hour = item.rtc_hour + 5'd12;
              end
            end
            tw = 1'b1;
            set_clock_mode_next = o_mode;
            alarm_mode_next     = o_mode;
          end
          PAGE_CLOCK: begin
            if (item.rtc_mode == MODE_AM) begin
              o_mode = MODE_PM;
            end else if (item.rtc_mode == MODE_PM) begin
              o_mode = MODE_AM;
            end
            if (o_mode != MODE_RAW) begin
              set_clock_mode_next = o_mode;
            end
            tw = 1'b1;
          end
          PAGE_CALENDAR: begin
            set_weekday_next = 3'(step_wrap(8'(set_weekday), WEEKDAY_MAX, 8'd1));
            o_wday = set_weekday_next;
            cw = 1'b1;
          end
          default: begin
            if (alarm_mode == MODE_AM) begin
              am_tmp = MODE_PM;
            end else if (alarm_mode == MODE_PM) begin
              am_tmp = MODE_AM;
            end
            alarm_mode_next = am_tmp;
            alarm_hour_next = norm_alarm_hour(am_tmp, alarm_hour);
          end
        endcase
      end
      FUNC_HOUR: begin
        case (page)
          PAGE_NORMAL: begin
            if (alarm_ringing) begin
              drive = DRIVE_LED_OFF;
              alarm_ringing_next = 1'b0;
            end else begin
              alarm_enabled_next = !alarm_enabled;
            end
          end
          PAGE_CLOCK: begin
            if (set_clock_mode == MODE_24) begin
              set_clock_hour_next = 5'(step_wrap(8'(set_clock_hour), HOUR24_MAX, 8'd0));
              o_hour = set_clock_hour_next;
              tw = 1'b1;
            end else if (set_clock_mode == MODE_AM || set_clock_mode == MODE_PM) begin
              set_clock_hour_next = 5'(step_wrap(8'(set_clock_hour), HOUR12_MAX, 8'd1));
              o_hour = set_clock_hour_next;
              tw = 1'b1;
            end
          end
          PAGE_CALENDAR: begin
            set_day_of_month_next = 5'(step_wrap(8'(set_day_of_month), MDAY_MAX, 8'd1));
            o_mday = set_day_of_month_next;
            cw = 1'b1;
          end
          default: begin
            if (alarm_mode == MODE_24) begin
              ah_tmp = 5'(step_wrap(8'(alarm_hour), HOUR24_MAX, 8'd0));
            end else if (alarm_mode == MODE_AM || alarm_mode == MODE_PM) begin
              ah_tmp = 5'(step_wrap(8'(alarm_hour), HOUR12_MAX, 8'd1));
            end
            alarm_hour_next = norm_alarm_hour(alarm_mode, ah_tmp);
          end
        endcase
      end
      FUNC_MINUTE: begin
        case (page)
          PAGE_NORMAL: begin
            blt = 1'b1;
          end
          PAGE_CLOCK: begin
            set_clock_minute_next = 6'(step_wrap(8'(set_clock_minute), MINUTE_MAX, 8'd0));
            o_minute = set_clock_minute_next;
            tw = 1'b1;
          end
          PAGE_CALENDAR: begin
            cal_month_next = 4'(step_wrap(8'(cal_month), MONTH_MAX, 8'd1));
            o_month = cal_month_next;
            cw = 1'b1;
          end
          default: begin
            alarm_minute_next = 6'(step_wrap(8'(alarm_minute), MINUTE_MAX, 8'd0));
            alarm_hour_next   = norm_alarm_hour(alarm_mode, alarm_hour);
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.time_write       = tw;
    result.cal_write        = cw;
    result.new_mode         = tw ? o_mode : 2'd0;
    result.new_hour         = tw ? o_hour : 5'd0;
    result.new_minute       = tw ? o_minute : 6'd0;
    result.new_weekday      = cw ? o_wday : 3'd0;
    result.new_day_of_month = cw ? o_mday : 5'd0;
    result.new_month        = cw ? o_month : 4'd0;
    result.drive_action     = drive;
    result.backlight_toggle = blt;
    result.menu_now         = page_next;
    result.alarm_on         = alarm_enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_limit <= RING_LIMIT_RESET;
    end else if (cfg_valid) begin
      ring_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page             <= PAGE_NORMAL;
      set_clock_mode   <= MODE_24;
      set_clock_hour   <= 5'd0;
      set_clock_minute <= 6'd0;
      set_weekday      <= 3'd1;
      set_day_of_month <= 5'd1;
      cal_month        <= 4'd1;
      alarm_mode       <= MODE_24;
      alarm_hour       <= 5'd0;
      alarm_minute     <= 6'd0;
      alarm_enabled    <= 1'b0;
      alarm_ringing    <= 1'b0;
      ring_count       <= 8'd0;
    end else if (fire) begin
      page             <= page_next;
      set_clock_mode   <= set_clock_mode_next;
      set_clock_hour   <= set_clock_hour_next;
      set_clock_minute <= set_clock_minute_next;
      set_weekday      <= set_weekday_next;
      set_day_of_month <= set_day_of_month_next;
      cal_month        <= cal_month_next;
      alarm_mode       <= alarm_mode_next;
      alarm_hour       <= alarm_hour_next;
      alarm_minute     <= alarm_minute_next;
      alarm_enabled    <= alarm_enabled_next;
      alarm_ringing    <= alarm_ringing_next;
      ring_count       <= ring_count_next;
    end
  end

  a_menu_advance: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == FUNC_MENU |=> page == page_t'($past(page) + 2'd1))
    else $error("menu page did not advance");

  a_tick_ignored: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == FUNC_TICK && page != PAGE_NORMAL
    |=> $stable(ring_count) && $stable(alarm_ringing))
    else $error("tick changed ringing state outside normal view");

  a_cal_page: assert property (@(posedge clk) disable iff (rst)
    fire && cw |-> page == PAGE_CALENDAR && !tw)
    else $error("calendar write outside calendar page");

  a_no_ring_no_count: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == FUNC_TICK && page == PAGE_NORMAL && !alarm_enabled
    |=> ring_count == 8'd0)
    else $error("ring count advanced while alarm disabled");

endmodule

// ===== rtl/acbc_out_stage.sv =====
module acbc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  acbc_pkg::result_t result_in,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output acbc_pkg::result_t result
);
  import acbc_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      result <= result_in;
    end
  end

endmodule

// ===== tb/alarm_clock_button_controller_checker.sv =====
module alarm_clock_button_controller_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] func,
  input  logic [1:0] rtc_mode,
  input  logic [4:0] rtc_hour,
  input  logic [5:0] rtc_minute,
  input  logic [5:0] rtc_second,
  input  logic [2:0] rtc_weekday,
  input  logic [4:0] rtc_day_of_month,
  input  logic [3:0] rtc_month,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       time_write,
  input  logic       cal_write,
  input  logic [1:0] new_mode,
  input  logic [4:0] new_hour,
  input  logic [5:0] new_minute,
  input  logic [2:0] new_weekday,
  input  logic [4:0] new_day_of_month,
  input  logic [3:0] new_month,
  input  logic [1:0] drive_action,
  input  logic       backlight_toggle,
  input  logic [1:0] menu_now,
  input  logic       alarm_on,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       wrap_up,
  output int         failures
);
  import acbc_pkg::*;

  result_t    pending_results[$];
  int         fail_total = 0;
  logic [7:0] ring_limit;
  page_t      menu_pg;
  logic [1:0] clk_mode;
  logic [4:0] clk_hour;
  logic [5:0] clk_minute;
  logic [2:0] cal_wday;
  logic [4:0] cal_mday;
  logic [3:0] cal_month;
  logic [1:0] al_mode;
  logic [4:0] al_hour;
  logic [5:0] al_minute;
  logic       al_enabled;
  logic       al_ringing;
  logic [7:0] ring_count;

  assign failures = fail_total;

  function automatic int unsigned bump(int unsigned v, int unsigned top, int unsigned lo);
    return (v + 1 > top) ? lo : v + 1;
  endfunction

  function automatic logic [4:0] fold_alarm_hour(logic [1:0] m, logic [4:0] h);
    if (m != MODE_AM && m != MODE_PM) return h;
    if (h == 5'd0) return 5'd12;
    if (h > 5'd12 && h <= 5'd23) return h - 5'd12;
    return h;
  endfunction

  function automatic result_t advance(item_t it);
    result_t    r;
    logic [1:0] m;
    logic [4:0] h;
    logic [5:0] mi;
    logic [2:0] wd;
    logic [4:0] md;
    logic [3:0] mo;
    logic [1:0] next_pg;
    r  = '0;
    m  = it.rtc_mode;
    h  = it.rtc_hour;
    mi = it.rtc_minute;
    wd = it.rtc_weekday;
    md = it.rtc_day_of_month;
    mo = it.rtc_month;
    case (it.func)
      FUNC_TICK: begin
        if (menu_pg == PAGE_NORMAL) begin
          if (al_mode == m && al_hour == h && al_minute == mi && it.rtc_second == 6'd0)
            al_ringing = 1'b1;
          if (!al_ringing || !al_enabled) begin
            ring_count = 8'd0;
            r.drive_action = DRIVE_ALL_OFF;
          end else begin
            if (ring_count >= ring_limit) begin
              al_ringing = 1'b0;
              ring_count = 8'd0;
            end else begin
              ring_count = ring_count + 8'd1;
            end
            r.drive_action = DRIVE_TOGGLE;
          end
        end
      end
      FUNC_MENU: begin
        next_pg = menu_pg + 2'd1;
        menu_pg = page_t'(next_pg);
        if (menu_pg == PAGE_NORMAL) begin
          clk_hour   = 5'd0;
          clk_minute = 6'd0;
          cal_wday   = 3'd1;
          cal_mday   = 5'd1;
          cal_month  = 4'd1;
        end else if (menu_pg == PAGE_ALARM) begin
          al_hour = fold_alarm_hour(al_mode, al_hour);
        end
      end
      FUNC_MODE: begin
        case (menu_pg)
          PAGE_NORMAL: begin
            if (m == MODE_24) begin
              if (h == 5'd0) begin
                m = MODE_AM;
                h = 5'd12;
              end else if (h < 5'd12) begin
                m = MODE_AM;
              end else if (h == 5'd12) begin
                m = MODE_PM;
              end else begin
                m = MODE_PM;
                h = h - 5'd12;
              end
            end else if (m == MODE_AM) begin
              m = MODE_24;
              if (h == 5'd12) h = 5'd0;
            end else if (m == MODE_PM) begin
              m = MODE_24;
              if (h != 5'd12) h = h + 5'd12;
            end
            r.time_write = 1'b1;
            clk_mode = m;
            al_mode = m;
          end
          PAGE_CLOCK: begin
            if (m == MODE_AM) m = MODE_PM;
            else if (m == MODE_PM) m = MODE_AM;
            if (m != MODE_RAW) clk_mode = m;
            r.time_write = 1'b1;
          end
          PAGE_CALENDAR: begin
            cal_wday = 3'(bump(cal_wday, WEEKDAY_MAX, 1));
            wd = cal_wday;
            r.cal_write = 1'b1;
          end
          default: begin
            if (al_mode == MODE_AM) al_mode = MODE_PM;
            else if (al_mode == MODE_PM) al_mode = MODE_AM;
            al_hour = fold_alarm_hour(al_mode, al_hour);
          end
        endcase
      end
      FUNC_HOUR: begin
        case (menu_pg)
          PAGE_NORMAL: begin
            if (al_ringing) begin
              r.drive_action = DRIVE_LED_OFF;
              al_ringing = 1'b0;
            end else begin
              al_enabled = ~al_enabled;
            end
          end
          PAGE_CLOCK: begin
            if (clk_mode == MODE_24) begin
              clk_hour = 5'(bump(clk_hour, HOUR24_MAX, 0));
              h = clk_hour;
              r.time_write = 1'b1;
            end else if (clk_mode == MODE_AM || clk_mode == MODE_PM) begin
              clk_hour = 5'(bump(clk_hour, HOUR12_MAX, 1));
              h = clk_hour;
              r.time_write = 1'b1;
            end
          end
          PAGE_CALENDAR: begin
            cal_mday = 5'(bump(cal_mday, MDAY_MAX, 1));
            md = cal_mday;
            r.cal_write = 1'b1;
          end
          default: begin
            if (al_mode == MODE_24) al_hour = 5'(bump(al_hour, HOUR24_MAX, 0));
            else if (al_mode == MODE_AM || al_mode == MODE_PM)
              al_hour = 5'(bump(al_hour, HOUR12_MAX, 1));
            al_hour = fold_alarm_hour(al_mode, al_hour);
          end
        endcase
      end
      FUNC_MINUTE: begin
        case (menu_pg)
          PAGE_NORMAL: r.backlight_toggle = 1'b1;
          PAGE_CLOCK: begin
            clk_minute = 6'(bump(clk_minute, MINUTE_MAX, 0));
            mi = clk_minute;
            r.time_write = 1'b1;
          end
          PAGE_CALENDAR: begin
            cal_month = 4'(bump(cal_month, MONTH_MAX, 1));
            mo = cal_month;
            r.cal_write = 1'b1;
          end
          default: begin
            al_minute = 6'(bump(al_minute, MINUTE_MAX, 0));
            al_hour = fold_alarm_hour(al_mode, al_hour);
          end
        endcase
      end
      default: ;
    endcase
    if (r.time_write) begin
      r.new_mode   = m;
      r.new_hour   = h;
      r.new_minute = mi;
    end
    if (r.cal_write) begin
      r.new_weekday      = wd;
      r.new_day_of_month = md;
      r.new_month        = mo;
    end
    r.menu_now = menu_pg;
    r.alarm_on = al_enabled;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    item_t   req;
    req = {func, rtc_mode, rtc_hour, rtc_minute, rtc_second,
           rtc_weekday, rtc_day_of_month, rtc_month};
    if (rst) begin
      ring_limit = RING_LIMIT_RESET;
      menu_pg    = PAGE_NORMAL;
      clk_mode   = MODE_24;
      clk_hour   = 5'd0;
      clk_minute = 6'd0;
      cal_wday   = 3'd1;
      cal_mday   = 5'd1;
      cal_month  = 4'd1;
      al_mode    = MODE_24;
      al_hour    = 5'd0;
      al_minute  = 6'd0;
      al_enabled = 1'b0;
      al_ringing = 1'b0;
      ring_count = 8'd0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) ring_limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting");
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          compare_field("time_write", want.time_write, time_write);
          compare_field("cal_write", want.cal_write, cal_write);
          compare_field("new_mode", want.new_mode, new_mode);
          compare_field("new_hour", want.new_hour, new_hour);
          compare_field("new_minute", want.new_minute, new_minute);
          compare_field("new_weekday", want.new_weekday, new_weekday);
          compare_field("new_day_of_month", want.new_day_of_month, new_day_of_month);
          compare_field("new_month", want.new_month, new_month);
          compare_field("drive_action", want.drive_action, drive_action);
          compare_field("backlight_toggle", want.backlight_toggle, backlight_toggle);
          compare_field("menu_now", want.menu_now, menu_now);
          compare_field("alarm_on", want.alarm_on, alarm_on);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(advance(req));
      if (wrap_up && pending_results.size() != 0) begin
        $error("%0d results never arrived", pending_results.size());
        fail_total += pending_results.size();
        pending_results.delete();
      end
    end
  end

endmodule

// ===== tb/alarm_clock_button_controller_top_test.sv =====
module alarm_clock_button_controller_top_test;
  import acbc_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 135;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [2:0] FUNC_LAST   = 3'd7;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] func;
  logic [1:0] rtc_mode;
  logic [4:0] rtc_hour;
  logic [5:0] rtc_minute;
  logic [5:0] rtc_second;
  logic [2:0] rtc_weekday;
  logic [4:0] rtc_day_of_month;
  logic [3:0] rtc_month;
  logic       out_valid;
  logic       out_stall;
  logic       time_write;
  logic       cal_write;
  logic [1:0] new_mode;
  logic [4:0] new_hour;
  logic [5:0] new_minute;
  logic [2:0] new_weekday;
  logic [4:0] new_day_of_month;
  logic [3:0] new_month;
  logic [1:0] drive_action;
  logic       backlight_toggle;
  logic [1:0] menu_now;
  logic       alarm_on;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       wrap_up;
  int         failures;

  int         sent = 0;
  int         got = 0;
  int         cycle_count = 0;
  logic       gaps_on = 1'b0;
  logic       hold_ask = 1'b0;

  page_t      cur_page = PAGE_NORMAL;
  logic [1:0] al_mode_seen = MODE_24;
  logic [4:0] al_hour_seen = 5'd0;
  logic [5:0] al_minute_seen = 6'd0;

  always #5 clk = ~clk;

  alarm_clock_button_controller_top u_dut (.*);

  alarm_clock_button_controller_checker u_check (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) got <= got + 1;
  end

  function automatic logic [4:0] fold_hour12(logic [1:0] m, logic [4:0] h);
    if (m != MODE_AM && m != MODE_PM) return h;
    if (h == 5'd0) return 5'd12;
    if (h > 5'd12 && h <= 5'd23) return h - 5'd12;
    return h;
  endfunction

  // track the alarm setting so that ticks can hit it
  function automatic void note_request(item_t it);
    logic [1:0] np;
    logic       twelve;
    twelve = (al_mode_seen == MODE_AM || al_mode_seen == MODE_PM);
    if (it.func == FUNC_MENU) begin
      np = cur_page + 2'd1;
      cur_page = page_t'(np);
      if (cur_page == PAGE_ALARM) al_hour_seen = fold_hour12(al_mode_seen, al_hour_seen);
    end else if (it.func == FUNC_MODE && cur_page == PAGE_NORMAL) begin
      if (it.rtc_mode == MODE_24) al_mode_seen = (it.rtc_hour < 5'd12) ? MODE_AM : MODE_PM;
      else if (it.rtc_mode != MODE_RAW) al_mode_seen = MODE_24;
      else al_mode_seen = MODE_RAW;
    end else if (cur_page == PAGE_ALARM) begin
      if (it.func == FUNC_MODE && twelve) begin
        al_mode_seen = (al_mode_seen == MODE_AM) ? MODE_PM : MODE_AM;
      end else if (it.func == FUNC_HOUR && al_mode_seen == MODE_24) begin
        al_hour_seen = (al_hour_seen >= 5'd23) ? 5'd0 : al_hour_seen + 5'd1;
      end else if (it.func == FUNC_HOUR && twelve) begin
        al_hour_seen = (al_hour_seen >= 5'd12) ? 5'd1 : al_hour_seen + 5'd1;
      end else if (it.func == FUNC_MINUTE) begin
        al_minute_seen = (al_minute_seen >= 6'd59) ? 6'd0 : al_minute_seen + 6'd1;
      end
      al_hour_seen = fold_hour12(al_mode_seen, al_hour_seen);
    end
  endfunction

  function automatic item_t mk(logic [2:0] f, logic [1:0] m, logic [4:0] h, logic [5:0] mi,
                               logic [5:0] s, logic [2:0] wd, logic [4:0] md,
                               logic [3:0] mo);
    return {f, m, h, mi, s, wd, md, mo};
  endfunction

  function automatic item_t pick_fields(logic [2:0] f);
    item_t it;
    it.func = f;
    it.rtc_mode = ($urandom_range(0, 7) == 0) ? MODE_RAW : 2'($urandom_range(0, 2));
    it.rtc_hour = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(24, 31)
                                                 : $urandom_range(0, 23));
    it.rtc_minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
                                                   : $urandom_range(0, 59));
    it.rtc_second = 6'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63));
    it.rtc_weekday = 3'($urandom_range(0, 7));
    it.rtc_day_of_month = 5'($urandom_range(0, 31));
    it.rtc_month = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(13, 15)
                                                  : $urandom_range(0, 12));
    return it;
  endfunction

  function automatic item_t alarm_tick();
    item_t it;
    it = pick_fields(FUNC_TICK);
    it.rtc_mode = al_mode_seen;
    it.rtc_hour = al_hour_seen;
    it.rtc_minute = al_minute_seen;
    it.rtc_second = 6'd0;
    return it;
  endfunction

  task automatic send_request(input item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    func = it.func;
    rtc_mode = it.rtc_mode;
    rtc_hour = it.rtc_hour;
    rtc_minute = it.rtc_minute;
    rtc_second = it.rtc_second;
    rtc_weekday = it.rtc_weekday;
    rtc_day_of_month = it.rtc_day_of_month;
    rtc_month = it.rtc_month;
    do @(posedge clk); while (in_stall);
    sent++;
    note_request(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (got != sent) @(negedge clk);
  endtask

  task automatic write_ring_limit(input logic [7:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic go_to_page(input page_t p);
    while (cur_page != p) send_request(pick_fields(FUNC_MENU));
  endtask

  task automatic run_scenario();
    int         kind;
    int         n;
    logic [2:0] f;
    item_t      it;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      go_to_page(PAGE_NORMAL);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 12);
      send_request(alarm_tick());
      repeat (n) begin
        case ($urandom_range(0, 19))
          0, 1:    it = pick_fields(FUNC_HOUR);
          2:       it = pick_fields(FUNC_MINUTE);
          3:       it = pick_fields(FUNC_MODE);
          4:       it = alarm_tick();
          default: it = pick_fields(FUNC_TICK);
        endcase
        send_request(it);
      end
    end else if (kind < 85) begin
      if (kind < 55) go_to_page(PAGE_CLOCK);
      else if (kind < 70) go_to_page(PAGE_CALENDAR);
      else go_to_page(PAGE_ALARM);
      if ($urandom_range(0, 3) == 0) begin
        f = 3'(FUNC_MODE + $urandom_range(0, 2));
        repeat ($urandom_range(60, 70)) send_request(pick_fields(f));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          f = 3'(FUNC_MODE + $urandom_range(0, 2));
          if ($urandom_range(0, 9) == 0) f = FUNC_TICK;
          send_request(pick_fields(f));
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_request(pick_fields(3'($urandom_range(0, FUNC_LAST))));
    end
  endtask

  initial begin : sink
    int   burst;
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        out_stall = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("alarm_clock_button_controller_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] limits [6];
    int         start;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_TICK;
    rtc_mode = MODE_24;
    rtc_hour = '0;
    rtc_minute = '0;
    rtc_second = '0;
    rtc_weekday = '0;
    rtc_day_of_month = '0;
    rtc_month = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    wrap_up = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    write_ring_limit(8'd1);
    send_request(mk(FUNC_TICK, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_HOUR, MODE_AM, 1, 1, 1, 0, 0, 0));
    send_request(mk(FUNC_HOUR, MODE_PM, 2, 2, 2, 7, 31, 15));
    send_request(mk(FUNC_TICK, MODE_24, 0, 0, 0, 7, 31, 12));
    send_request(mk(FUNC_TICK, MODE_RAW, 31, 63, 63, 7, 31, 15));
    send_request(mk(FUNC_MINUTE, MODE_24, 5, 5, 5, 1, 1, 1));
    send_request(mk(FUNC_MODE, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_MODE, MODE_24, 12, 30, 0, 2, 2, 2));
    send_request(mk(FUNC_MODE, MODE_24, 23, 59, 59, 7, 31, 12));
    send_request(mk(FUNC_MODE, MODE_AM, 12, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_MODE, MODE_PM, 31, 63, 63, 7, 31, 15));
    send_request(mk(FUNC_MODE, MODE_RAW, 31, 63, 63, 7, 31, 15));
    for (int f = FUNC_MINUTE + 1; f <= FUNC_LAST; f++)
      send_request(mk(3'(f), MODE_RAW, 31, 63, 63, 7, 31, 15));
    send_request(mk(FUNC_MENU, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_HOUR, MODE_RAW, 9, 9, 9, 3, 3, 3));
    send_request(mk(FUNC_MODE, MODE_PM, 11, 45, 0, 4, 4, 4));
    send_request(mk(FUNC_HOUR, MODE_AM, 11, 45, 0, 4, 4, 4));
    send_request(mk(FUNC_MINUTE, MODE_AM, 1, 59, 0, 4, 4, 4));
    send_request(mk(FUNC_MENU, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_MODE, MODE_24, 0, 0, 0, 7, 31, 12));
    send_request(mk(FUNC_HOUR, MODE_24, 0, 0, 0, 0, 0, 0));
    send_request(mk(FUNC_MINUTE, MODE_24, 0, 0, 0, 7, 31, 15));
    send_request(mk(FUNC_MENU, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_HOUR, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_MINUTE, MODE_24, 0, 0, 0, 1, 1, 1));
    send_request(mk(FUNC_MENU, MODE_24, 0, 0, 0, 1, 1, 1));

    limits = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0, RING_LIMIT_RESET};
    limits[4] = 8'($urandom_range(1, 254));
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_ring_limit(limits[p]);
      gaps_on = (p != 5);
      hold_ask = (p == 2);
      start = sent;
      while (sent - start < PHASE_ITEMS) run_scenario();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    wrap_up = 1'b1;
    @(negedge clk);
    wrap_up = 1'b0;
    @(negedge clk);
    if (failures == 0) begin
      $display("alarm_clock_button_controller_top regression: pass");
    end else begin
      $display("alarm_clock_button_controller_top regression: fail");
    end
    $finish;
  end

endmodule
